FILE: src/wes_pkg.sv
package wes_pkg;

  // Field widths of the words on both channels.
  localparam int unsigned ID_W   = 16;
  localparam int unsigned CHN_W  = 16;

  // Datapath widths.
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned TOT_W  = 48;
  localparam int unsigned HALF_W = 24;
  localparam int unsigned PROD_W = CNT_W + CHN_W;
  localparam int unsigned LHS_W  = 64;
  localparam int unsigned SCUM_W = 63;

  // Operation codes carried in the op field.
  localparam logic OP_HIT    = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // 100 percent in unsigned Q8.8, and the saturation value of a counter.
  localparam logic [CHN_W-1:0] FULL_SCALE = 16'd25600;
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

  typedef logic [ID_W-1:0]   edge_id_t;
  typedef logic [CHN_W-1:0]  chance_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [TOT_W-1:0]  total_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [LHS_W-1:0]  lhs_t;
  typedef logic [SCUM_W-1:0] scum_t;

endpackage

FILE: src/wes_in_if.sv
interface wes_in_if;
  import wes_pkg::*;

  logic     valid;
  logic     ready;
  logic     op;
  edge_id_t edge_id;
  chance_t  chance_q;

  modport source (output valid, output op, output edge_id, output chance_q, input ready);
  modport sink   (input valid, input op, input edge_id, input chance_q, output ready);
endinterface

FILE: src/wes_out_if.sv
interface wes_out_if;
  import wes_pkg::*;

  logic     valid;
  logic     ready;
  logic     found;
  edge_id_t selected_id;

  modport source (output valid, output found, output selected_id, input ready);
  modport sink   (input valid, input found, input selected_id, output ready);
endinterface

FILE: src/weighted_edge_selector.sv
// Channel   Dir  Word fields                 Handshake
// in_i      in   op, edge_id, chance_q       valid/ready, taken when both high
// out_o     out  found, selected_id          valid/ready, taken when both high
//
// An in-range hit word passes from acceptance to its result through a read, a write back and the output step.
// A select word walks at most every id: the counter memory has one read port
// and is walked one id per cycle, with a two-step 16 x 48 product in front of the walk.
// After reset a clearing pass writes zero to every counter, with in_i.ready low. A result
// waiting in the output register does not block acceptance of the next word; that word
// only stalls at its end until the register is free.
module weighted_edge_selector #(
  parameter int unsigned NUM_EDGES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wes_in_if.sink    in_i,
  wes_out_if.source out_o
);
  import wes_pkg::*;

  localparam int unsigned IW = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_EDGES - 1);

  typedef logic [IW-1:0] idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HIT_RD,
    S_HIT_WR,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ACC,
    S_WALK,
    S_DONE
  } state_e;

  state_e   state_q, state_d;
  idx_t     addr_q, addr_d;
  idx_t     id_q, id_d;
  chance_t  chn_q, chn_d;
  total_t   total_q, total_d;
  lhs_t     lhs_q, lhs_d;
  scum_t    scum_q, scum_d;
  prod_t    prod_q, prod_d;
  logic     issue_q, issue_d;
  logic     rd_vld_q, rd_vld_d;
  idx_t     rd_idx_q, rd_idx_d;
  logic     prod_vld_q, prod_vld_d;
  idx_t     prod_idx_q, prod_idx_d;
  logic     res_found_q, res_found_d;
  edge_id_t res_id_q, res_id_d;
  logic     out_valid_q, out_valid_d;
  logic     out_found_q, out_found_d;
  edge_id_t out_id_q, out_id_d;

  // Counter memory, one write and one registered read per cycle.
  count_t mem_q [NUM_EDGES];
  count_t rd_data_q;
  idx_t   rd_addr;
  logic   wr_en;
  idx_t   wr_addr;
  count_t wr_data;

  // Shared multiplier operands.
  count_t  mul_a;
  chance_t mul_b;

  logic  in_fire;
  logic  in_range;
  logic  out_free;
  scum_t scum_sum;
  logic  hit_now;

  assign in_i.ready        = (state_q == S_IDLE);
  assign in_fire           = in_i.valid && in_i.ready;
  assign in_range          = (17'(in_i.edge_id) < 17'(NUM_EDGES));
  assign out_free          = !out_valid_q || out_o.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.selected_id = out_id_q;

  // Running scaled sum and the roulette compare of the walk.
  assign scum_sum = scum_q + SCUM_W'(prod_q);
  assign hit_now  = prod_vld_q && (prod_q != '0) && (lhs_q < LHS_W'(scum_sum));

  // Operand selection for the one multiplier: two halves of chance * total, then
  // each counter scaled by 100 percent during the walk.
  always_comb begin
    case (state_q)
      S_MUL_LO: begin
        mul_a = CNT_W'(total_q[HALF_W-1:0]);
        mul_b = chn_q;
      end
      S_MUL_HI: begin
        mul_a = CNT_W'(total_q[TOT_W-1:HALF_W]);
        mul_b = chn_q;
      end
      default: begin
        mul_a = rd_data_q;
        mul_b = FULL_SCALE;
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_addr = addr_q;
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = '0;
    case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_HIT_RD: begin
        rd_addr = id_q;
      end
      S_HIT_WR: begin
        wr_en   = (rd_data_q != COUNT_MAX);
        wr_addr = id_q;
        wr_data = rd_data_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    id_d        = id_q;
    chn_d       = chn_q;
    total_d     = total_q;
    lhs_d       = lhs_q;
    scum_d      = scum_q;
    prod_d      = PROD_W'(mul_a) * PROD_W'(mul_b);
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    prod_vld_d  = rd_vld_q;
    prod_idx_d  = rd_idx_q;
    res_found_d = res_found_q;
    res_id_d    = res_id_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_found_d = out_found_q;
    out_id_d    = out_id_q;

    case (state_q)
      S_CLEAR: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST_IDX) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          id_d  = IW'(in_i.edge_id);
          chn_d = in_i.chance_q;
          if (in_i.op == OP_SELECT) begin
            state_d = S_MUL_LO;
          end else if (in_range) begin
            state_d = S_HIT_RD;
          end else begin
            res_found_d = 1'b0;
            res_id_d    = '0;
            state_d     = S_DONE;
          end
        end
      end
      S_HIT_RD: begin
        state_d = S_HIT_WR;
      end
      S_HIT_WR: begin
        if (rd_data_q != COUNT_MAX) begin
          total_d = total_q + 1'b1;
        end
        res_found_d = 1'b1;
        res_id_d    = '0;
        state_d     = S_DONE;
      end
      S_MUL_LO: begin
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        lhs_d   = LHS_W'(prod_q);
        state_d = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        lhs_d      = lhs_q + (LHS_W'(prod_q) << HALF_W);
        scum_d     = '0;
        addr_d     = '0;
        issue_d    = 1'b1;
        prod_vld_d = 1'b0;
        state_d    = S_WALK;
      end
      S_WALK: begin
        // Issue the next read.
        if (issue_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q;
          addr_d   = addr_q + 1'b1;
          if (addr_q == LAST_IDX) begin
            issue_d = 1'b0;
          end
        end
        // Accumulate and test the counter that left the multiplier.
        if (prod_vld_q) begin
          scum_d = scum_sum;
          if (hit_now) begin
            res_found_d = 1'b1;
            res_id_d    = ID_W'(prod_idx_q);
            issue_d     = 1'b0;
            state_d     = S_DONE;
          end else if (prod_idx_q == LAST_IDX) begin
            res_found_d = 1'b0;
            res_id_d    = '0;
            state_d     = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_id_d    = res_id_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      total_q     <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      total_q     <= total_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      prod_vld_q  <= prod_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    chn_q       <= chn_d;
    lhs_q       <= lhs_d;
    scum_q      <= scum_d;
    prod_q      <= prod_d;
    rd_idx_q    <= rd_idx_d;
    prod_idx_q  <= prod_idx_d;
    res_found_q <= res_found_d;
    res_id_q    <= res_id_d;
    out_found_q <= out_found_d;
    out_id_q    <= out_id_d;
  end

endmodule

FILE: src/wes_checker.sv
module wes_checker #(
  parameter int unsigned NUM_EDGES = 1024
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 out_found_i,
  input wes_pkg::edge_id_t    out_selected_id_i
);
  import wes_pkg::*;

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_found_i) && $stable(out_selected_id_i))
    else $error("result word changed while stalled");

  // Every word leaves the idle state on acceptance, so ready drops after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken on consecutive cycles");

  // Nothing found means id zero.
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_selected_id_i == '0)
    else $error("nonzero id without a found edge");

  // A chosen edge lies inside the table.
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_found_i |-> 17'(out_selected_id_i) < 17'(NUM_EDGES))
    else $error("selected id beyond the table");

endmodule

bind weighted_edge_selector wes_checker #(
  .NUM_EDGES(NUM_EDGES)
) u_wes_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_found_i       (out_o.found),
  .out_selected_id_i (out_o.selected_id)
);
